>>> rtl/ffa_pkg.sv
package ffa_pkg;
    localparam int MEM_BYTES_DEF = 1024;
    localparam int LEN_W = 17;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NOFIT = 2'd1, ST_NOTFOUND = 2'd2, ST_BADSIZE = 2'd3
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [10:0] request_size;
        logic [9:0]  block_address;
    } cmd_t;

    typedef struct packed {
        logic [9:0] result_address;
        status_t    result_status;
    } rsp_t;

    // One table entry: start flag, allocated flag, length.
    typedef struct packed {
        logic             start;
        logic             alloc;
        logic [LEN_W-1:0] len;
    } entry_t;
endpackage

>>> rtl/ffa_ram.sv
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/ffa_ctrl.sv
module ffa_ctrl #(
    parameter int MEM_BYTES = ffa_pkg::MEM_BYTES_DEF,
    parameter int AW = $clog2(MEM_BYTES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ffa_pkg::cmd_t       cmd,
    output logic                busy,
    output logic                done,
    output ffa_pkg::rsp_t       rsp,
    output logic                we,
    output logic [AW-1:0]       waddr,
    output ffa_pkg::entry_t     wdata,
    output logic [AW-1:0]       raddr,
    input  ffa_pkg::entry_t     rdata
);
    import ffa_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RD    = 11'b00000000100,
        S_CHK   = 11'b00000001000,
        S_SPLIT = 11'b00000010000,
        S_FMARK = 11'b00000100000,
        S_NXT   = 11'b00001000000,
        S_FNXT  = 11'b00010000000,
        S_PREV  = 11'b00100000000,
        S_FPRV  = 11'b01000000000,
        S_RESP  = 11'b10000000000
    } state_t;

    localparam logic [LEN_W-1:0] FULL = LEN_W'(MEM_BYTES);

    state_t           state_reg, state_next;
    logic [AW:0]      clr_reg, clr_next;
    logic             op_reg, op_next;
    logic [LEN_W-1:0] size_reg, size_next;
    logic [LEN_W-1:0] target_reg, target_next;
    logic [LEN_W-1:0] a_reg, a_next;
    logic [LEN_W-1:0] prev_reg, prev_next;
    logic             hprev_reg, hprev_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             palloc_reg, palloc_next;
    rsp_t             rsp_reg, rsp_next;
    logic [LEN_W-1:0] nxt;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);
    assign rsp  = rsp_reg;
    assign nxt  = a_reg + len_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        size_next   = size_reg;
        target_next = target_reg;
        a_next      = a_reg;
        prev_next   = prev_reg;
        hprev_next  = hprev_reg;
        len_next    = len_reg;
        palloc_next = palloc_reg;
        rsp_next    = rsp_reg;
        we          = 1'b0;
        waddr       = a_reg[AW-1:0];
        wdata       = '0;
        raddr       = a_reg[AW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = (clr_reg == '0) ? entry_t'{1'b1, 1'b0, FULL} : entry_t'('0);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(MEM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd.operation;
                    size_next   = LEN_W'(cmd.request_size);
                    target_next = LEN_W'(cmd.block_address);
                    a_next      = '0;
                    hprev_next  = 1'b0;
                    if (cmd.operation == OP_ALLOC && cmd.request_size == '0)
                    begin
                        rsp_next   = '{10'd0, ST_BADSIZE};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (op_reg == OP_FREE && (a_reg >= FULL || a_reg >= target_reg))
                begin
                    if (a_reg != target_reg || a_reg >= FULL)
                    begin
                        rsp_next   = '{10'd0, ST_NOTFOUND};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
                else if (a_reg >= FULL)
                begin
                    rsp_next   = '{10'd0, ST_NOFIT};
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                len_next = rdata.len;
                if (op_reg == OP_ALLOC)
                begin
                    if (!rdata.start || rdata.len == '0)
                    begin
                        rsp_next   = '{10'd0, ST_NOFIT};
                        state_next = S_RESP;
                    end
                    else if (!rdata.alloc && rdata.len >= size_reg)
                    begin
                        we    = 1'b1;
                        wdata = '{1'b1, 1'b1, size_reg};
                        rsp_next = '{a_reg[9:0], ST_OK};
                        state_next = (rdata.len > size_reg) ? S_SPLIT : S_RESP;
                    end
                    else
                    begin
                        a_next     = a_reg + rdata.len;
                        state_next = S_RD;
                    end
                end
                else if (a_reg == target_reg)
                begin
                    if (!rdata.start)
                    begin
                        rsp_next   = '{10'd0, ST_NOTFOUND};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_FMARK;
                    end
                end
                else if (!rdata.start || rdata.len == '0)
                begin
                    rsp_next   = '{10'd0, ST_NOTFOUND};
                    state_next = S_RESP;
                end
                else
                begin
                    prev_next   = a_reg;
                    palloc_next = rdata.alloc;
                    hprev_next  = 1'b1;
                    a_next      = a_reg + rdata.len;
                    state_next  = S_RD;
                end
            end
            S_SPLIT:
            begin
                we    = 1'b1;
                waddr = AW'(a_reg + size_reg);
                wdata = '{1'b1, 1'b0, len_reg - size_reg};
                state_next = S_RESP;
            end
            S_FMARK:
            begin
                we    = 1'b1;
                wdata = '{1'b1, 1'b0, len_reg};
                raddr = nxt[AW-1:0];
                state_next = (nxt < FULL) ? S_NXT : S_PREV;
            end
            S_NXT:
            begin
                if (rdata.start && !rdata.alloc)
                begin
                    len_next = len_reg + rdata.len;
                    we       = 1'b1;
                    waddr    = nxt[AW-1:0];
                    wdata    = '0;
                    state_next = S_FNXT;
                end
                else
                begin
                    state_next = S_PREV;
                end
            end
            S_FNXT:
            begin
                we    = 1'b1;
                wdata = '{1'b1, 1'b0, len_reg};
                state_next = S_PREV;
            end
            S_PREV:
            begin
                raddr = prev_reg[AW-1:0];
                rsp_next = '{10'd0, ST_OK};
                state_next = (hprev_reg && !palloc_reg) ? S_FPRV : S_RESP;
            end
            S_FPRV:
            begin
                // The freed entry itself is cleared in the response cycle.
                we    = 1'b1;
                waddr = prev_reg[AW-1:0];
                wdata = '{1'b1, 1'b0, rdata.len + len_reg};
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
                if (op_reg == OP_FREE && hprev_reg && !palloc_reg
                    && rsp_reg.result_status == ST_OK)
                begin
                    we    = 1'b1;
                    waddr = a_reg[AW-1:0];
                    wdata = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        size_reg   <= size_next;
        target_reg <= target_next;
        a_reg      <= a_next;
        prev_reg   <= prev_next;
        hprev_reg  <= hprev_next;
        len_reg    <= len_next;
        palloc_reg <= palloc_next;
        rsp_reg    <= rsp_next;
    end
endmodule

>>> rtl/first_fit_allocator_coalescing.sv
// Channel   | Signals                 | Handshake
// command   | start, busy, cmd        | taken when start is high and busy is low
// response  | done, rsp               | valid for one cycle while done is high
//
// An allocate walks the partition table one partition at a time, each with a
// memory read and then a check. A free walks up to its address the same way,
// then marks the freed partition and merges it with free neighbors.
// After reset a clearing pass writes every table entry, with busy held high.
// The response cannot be stalled by the receiver.
module first_fit_allocator_coalescing #(
    parameter int MEM_BYTES = ffa_pkg::MEM_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ffa_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output ffa_pkg::rsp_t rsp
);
    import ffa_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;

    // The controller owns all sequencing; the RAM holds one entry per unit.
    ffa_ctrl #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy),
        .done(done), .rsp(rsp), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    ffa_ram #(.WIDTH($bits(entry_t)), .DEPTH(MEM_BYTES)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
endmodule

>>> rtl/ffa_checker.sv
module ffa_assertions (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input ffa_pkg::cmd_t cmd,
    input logic          busy,
    input logic          done,
    input ffa_pkg::rsp_t rsp
);
    import ffa_pkg::*;

    // A response is only shown while the block is busy.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without busy");

    // Responses last a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    // Failed transactions carry address zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.result_status != ST_OK) |-> rsp.result_address == '0)
        else $error("nonzero address on failure");

    // An accepted transaction makes the block busy.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept without busy");
endmodule

bind first_fit_allocator_coalescing ffa_assertions u_ffa_assertions (.*);

>>> tb/sv/ffa_checker.sv
`timescale 1ns / 100ps

// Watches the command and response channels, keeps its own copy of the
// partition table and compares every response with the predicted one.
module ffa_checker
    import ffa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    input  logic busy,
    input  logic done,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending_count,
    output int   resp_count
);
    localparam int MEM = MEM_BYTES_DEF;

    bit        part_start [MEM];
    bit        part_alloc [MEM];
    int unsigned part_len [MEM];
    rsp_t      expected_rsp_q [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        fail_count++;
    endtask

    task automatic table_reset();
        for (int i = 0; i < MEM; i++)
        begin
            part_start[i] = 0;
            part_alloc[i] = 0;
            part_len[i] = 0;
        end
        part_start[0] = 1;
        part_len[0] = MEM;
    endtask

    function automatic rsp_t mk_rsp(input int unsigned a, input status_t s);
        rsp_t r;
        r.result_address = a[9:0];
        r.result_status = s;
        return r;
    endfunction

    function automatic rsp_t predict_alloc(input int unsigned size);
        int unsigned a;
        int unsigned len;
        a = 0;
        if (size == 0)
            return mk_rsp(0, ST_BADSIZE);
        while (a < MEM)
        begin
            len = part_len[a];
            if (!part_start[a] || len == 0)
                break;
            if (!part_alloc[a] && len >= size)
            begin
                // Split off the unused tail as a new free partition.
                if (len > size)
                begin
                    part_start[a + size] = 1;
                    part_alloc[a + size] = 0;
                    part_len[a + size] = len - size;
                end
                part_alloc[a] = 1;
                part_len[a] = size;
                return mk_rsp(a, ST_OK);
            end
            a += len;
        end
        return mk_rsp(0, ST_NOFIT);
    endfunction

    function automatic rsp_t predict_free(input int unsigned addr);
        int unsigned a;
        int unsigned prev;
        int unsigned len;
        int unsigned nxt;
        bit have_prev;
        a = 0;
        prev = 0;
        have_prev = 0;
        while (a < MEM && a < addr)
        begin
            len = part_len[a];
            if (!part_start[a] || len == 0)
                break;
            prev = a;
            have_prev = 1;
            a += len;
        end
        if (a != addr || a >= MEM || !part_start[a])
            return mk_rsp(0, ST_NOTFOUND);
        part_alloc[a] = 0;
        len = part_len[a];
        nxt = a + len;
        // Merge with a free successor first, then with a free predecessor.
        if (nxt < MEM && part_start[nxt] && !part_alloc[nxt])
        begin
            len += part_len[nxt];
            part_len[a] = len;
            part_start[nxt] = 0;
            part_len[nxt] = 0;
        end
        if (have_prev && !part_alloc[prev])
        begin
            part_len[prev] += len;
            part_start[a] = 0;
            part_len[a] = 0;
        end
        return mk_rsp(0, ST_OK);
    endfunction

    assign pending_count = expected_rsp_q.size();

    initial
    begin
        fail_count = 0;
        resp_count = 0;
        table_reset();
    end

    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (cmd.operation == OP_ALLOC)
                    expected_rsp_q.push_back(predict_alloc(cmd.request_size));
                else
                    expected_rsp_q.push_back(predict_free(cmd.block_address));
            end
            if (done)
            begin
                resp_count++;
                if (expected_rsp_q.size() == 0)
                    report_mismatch("response with no command outstanding");
                else
                begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (rsp.result_address !== exp_rsp.result_address)
                        report_mismatch($sformatf("result_address %0d, expected %0d",
                            rsp.result_address, exp_rsp.result_address));
                    if (rsp.result_status !== exp_rsp.result_status)
                        report_mismatch($sformatf("result_status %0d, expected %0d",
                            rsp.result_status, exp_rsp.result_status));
                end
            end
        end
    end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the first-fit allocator. The checker beside the
// block predicts every response; this module only issues commands.
module tb_top;
    import ffa_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t cmd;
    logic busy;
    logic done;
    rsp_t rsp;
    int   fail_count;
    int   pending_count;
    int   resp_count;
    int   send_idle_pct;

    // Start addresses handed out by successful allocations, used to build
    // mostly well-formed free commands.
    logic [9:0] live_blocks [$];

    first_fit_allocator_coalescing i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    ffa_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .busy          (busy),
        .done          (done),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .resp_count    (resp_count)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // Track allocation results so later frees can target real blocks.
    always @(posedge clk)
    begin
        if (rst_n && done && rsp.result_status == ST_OK && rsp.result_address != 0)
            live_blocks.push_back(rsp.result_address);
    end

    // Issue one command transaction, with an optional random idle gap first.
    // The next command is driven in the same step that the previous one is
    // accepted, so start is never lowered and raised within one step.
    task automatic issue(input logic op, input logic [10:0] sz, input logic [9:0] ad);
        cmd_t c;
        c.operation = op;
        c.request_size = sz;
        c.block_address = ad;
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic random_item();
        int unsigned r;
        int idx;
        r = $urandom_range(99);
        if (r < 45)
        begin
            // Mostly small sizes, sometimes anything up to the 11-bit limit.
            if ($urandom_range(9) == 0)
                issue(OP_ALLOC, 11'($urandom), 10'($urandom));
            else
                issue(OP_ALLOC, 11'($urandom_range(64, 1)), 10'($urandom));
        end
        else if (r < 90 && live_blocks.size() > 0)
        begin
            idx = $urandom_range(live_blocks.size() - 1);
            issue(OP_FREE, 11'($urandom), live_blocks[idx]);
            live_blocks.delete(idx);
        end
        else if (r < 93)
            issue(OP_FREE, 11'($urandom), 10'd0);
        else
            issue(OP_FREE, 11'($urandom), 10'($urandom));
    endtask

    initial
    begin
        int wait_cycles;
        start = 1'b0;
        cmd = '0;
        send_idle_pct = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: size extremes, every status, freeing a free block,
        // merges on both sides, and address bits at both values.
        issue(OP_ALLOC, 11'd0, 10'd0);
        issue(OP_ALLOC, 11'd1025, 10'd0);
        issue(OP_ALLOC, 11'h7FF, 10'h3FF);
        issue(OP_ALLOC, 11'd1024, 10'd0);
        issue(OP_ALLOC, 11'd1, 10'd0);
        issue(OP_FREE, 11'd0, 10'd0);
        issue(OP_FREE, 11'd0, 10'd0);
        issue(OP_ALLOC, 11'd1, 10'd0);
        issue(OP_ALLOC, 11'd511, 10'd0);
        issue(OP_ALLOC, 11'd512, 10'd0);
        issue(OP_FREE, 11'd0, 10'h3FF);
        issue(OP_FREE, 11'd0, 10'd1);
        issue(OP_FREE, 11'd0, 10'd512);
        issue(OP_FREE, 11'd0, 10'd0);
        issue(OP_ALLOC, 11'd1, 10'd0);
        issue(OP_ALLOC, 11'd3, 10'd0);
        issue(OP_ALLOC, 11'd1023, 10'd0);
        issue(OP_ALLOC, 11'd1020, 10'd0);
        issue(OP_FREE, 11'd0, 10'd4);
        issue(OP_FREE, 11'd0, 10'd1);
        issue(OP_FREE, 11'd0, 10'd0);
        issue(OP_FREE, 11'h7FF, 10'h155);
        issue(OP_FREE, 11'h555, 10'h2AA);
        live_blocks.delete();

        // Random part in four phases of sender idling; the receiver cannot
        // stall, so only the sender's gaps vary.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: send_idle_pct = 0;
                1: send_idle_pct = 61;
                2: send_idle_pct = 28;
                default: send_idle_pct = 0;
            endcase
            for (int n = 0; n < 400; n++)
                random_item();
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);

        $display("Ran about 1620 allocate and free commands, %0d responses checked,",
            resp_count);
        $display("covering bad size, no fit, unknown addresses and merges.");
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Worst case: clearing pass plus a full table walk per command with gaps,
    // about 36 ms in all; the limit leaves a wide margin above that.
    initial
    begin
        #200ms;
        $display("FAILURE");
        $finish;
    end
endmodule

>>> first_fit_allocator_coalescing.f
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_ctrl.sv
rtl/first_fit_allocator_coalescing.sv
rtl/ffa_checker.sv
tb/sv/ffa_checker.sv
tb/sv/tb_top.sv
